// ===== rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, codes and opcode classification for the 6809 predecoder.
// ----------------------------------------------------------------------------
`default_nettype none
package isp_pkg;

	localparam logic [1:0] PH_OP   = 2'd0;
	localparam logic [1:0] PH_POST = 2'd1;
	localparam logic [1:0] PH_OPER = 2'd2;

	localparam logic [4:0] M_INH    = 5'd0;
	localparam logic [4:0] M_DIR    = 5'd1;
	localparam logic [4:0] M_IMM8   = 5'd2;
	localparam logic [4:0] M_IMM16  = 5'd3;
	localparam logic [4:0] M_EXT    = 5'd4;
	localparam logic [4:0] M_REL8   = 5'd5;
	localparam logic [4:0] M_REL16  = 5'd6;
	localparam logic [4:0] M_RLIST  = 5'd7;
	localparam logic [4:0] M_RPAIR  = 5'd8;
	localparam logic [4:0] M_INC1   = 5'd9;
	localparam logic [4:0] M_INC2   = 5'd10;
	localparam logic [4:0] M_DEC1   = 5'd11;
	localparam logic [4:0] M_DEC2   = 5'd12;
	localparam logic [4:0] M_CONST  = 5'd13;
	localparam logic [4:0] M_AOFF   = 5'd14;
	localparam logic [4:0] M_BOFF   = 5'd15;
	localparam logic [4:0] M_DOFF   = 5'd16;
	localparam logic [4:0] M_PCREL  = 5'd17;
	localparam logic [4:0] M_BADIDX = 5'd18;
	localparam logic [4:0] M_EXTIND = 5'd19;
	localparam logic [4:0] M_IDX    = 5'd20;

	localparam int QDEPTH = 2;

	// raw instruction, target arithmetic still to do
	typedef struct packed {
		logic [1:0]  page;
		logic [7:0]  opcode;
		logic [4:0]  mode;
		logic [15:0] opnd;
		logic [7:0]  post;
		logic [15:0] nxt;
		logic        ill;
		logic        flow;
		logic [2:0]  len;
	} raw_t;

	typedef struct packed {
		logic [4:0] mode;
		logic [1:0] nb;
		logic       flow;
		logic       ill;
	} cls_t;

	function automatic cls_t classify(input logic [1:0] page, input logic [7:0] code);
		cls_t c;
		logic [3:0] hi;
		logic [3:0] lo;
		hi = code[7:4];
		lo = code[3:0];
		c = '{mode: M_INH, nb: 2'd0, flow: 1'b0, ill: 1'b0};
		case (hi)
			4'h0, 4'h4, 4'h5, 4'h6, 4'h7: begin
				c.flow = (lo == 4'hE);
				if (lo == 4'h1 || lo == 4'h2 || lo == 4'h5 || lo == 4'hB ||
					code == 8'h4E || code == 8'h5E) begin
					c.ill = 1'b1;
				end else if (hi == 4'h0) begin
					c.mode = M_DIR; c.nb = 2'd1;
				end else if (hi == 4'h6) begin
					c.mode = M_IDX;
				end else if (hi == 4'h7) begin
					c.mode = M_EXT; c.nb = 2'd2;
				end
			end
			4'h1: begin
				case (lo)
					4'h2, 4'h3, 4'h9, 4'hD: ;
					4'h6: begin c.flow = 1'b1; c.mode = M_REL16; c.nb = 2'd2; end
					4'h7: begin c.mode = M_REL16; c.nb = 2'd2; end
					4'hA, 4'hC: begin c.mode = M_IMM8; c.nb = 2'd1; end
					4'hE, 4'hF: begin c.mode = M_RPAIR; c.nb = 2'd1; end
					default: c.ill = 1'b1;
				endcase
			end
			4'h2: begin
				c.flow = (lo == 4'h0);
				if (page == 2'd1) begin
					c.mode = M_REL16; c.nb = 2'd2;
				end else begin
					c.mode = M_REL8; c.nb = 2'd1;
				end
			end
			4'h3: begin
				if (lo < 4'h4) c.mode = M_IDX;
				else if (lo < 4'h8) begin c.mode = M_RLIST; c.nb = 2'd1; end
				else if (lo == 4'h8 || lo == 4'hE) c.ill = 1'b1;
				else if (lo == 4'h9 || lo == 4'hB) c.flow = 1'b1;
				else if (lo == 4'hC) begin c.mode = M_IMM8; c.nb = 2'd1; end
				else if (lo == 4'hF) begin c.mode = M_DIR; c.nb = 2'd1; end
			end
			default: begin
				case (hi[1:0])
					2'd0: begin
						if (lo[2:0] == 3'd7) c.ill = 1'b1;
						else if (lo == 4'hD) begin
							if (hi[2]) c.ill = 1'b1;
							else begin c.mode = M_REL8; c.nb = 2'd1; end
						end else if (lo == 4'h3 || lo == 4'hC || lo == 4'hE) begin
							c.mode = M_IMM16; c.nb = 2'd2;
						end else begin
							c.mode = M_IMM8; c.nb = 2'd1;
						end
					end
					2'd1: begin c.mode = M_DIR; c.nb = 2'd1; end
					2'd2: c.mode = M_IDX;
					default: begin c.mode = M_EXT; c.nb = 2'd2; end
				endcase
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/instruction_stream_predecoder.sv =====
// ----------------------------------------------------------------------------
// instruction_stream_predecoder
// 6809 instruction predecoder: code bytes in, one record per instruction out.
// ----------------------------------------------------------------------------
// Input channel: code_byte and byte_addr, a transfer on valid_in && ready_in.
// Output channel: one record per finished instruction, a transfer on
// valid && ready.
// One code byte is taken every cycle while the queue is not full. A record is
// written into the queue on the transfer of its last byte and then moves into
// the output register once that register is empty or being taken.
// A two-entry queue sits between tracker and output register; when the
// receiver stalls the queue fills and ready_in drops only once it is full.
// Reset clears the tracker to expect an opcode and empties queue and output.
// ----------------------------------------------------------------------------
`default_nettype none
module instruction_stream_predecoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_in,
	output logic             ready_in,
	input  wire logic [7:0]  code_byte,
	input  wire logic [15:0] byte_addr,
	output logic             valid,
	input  wire logic        ready,
	output logic [1:0]       page,
	output logic [7:0]       opcode,
	output logic [4:0]       addr_mode,
	output logic [15:0]      operand,
	output logic [1:0]       index_reg,
	output logic             indirect,
	output logic             illegal,
	output logic             flow_break,
	output logic [2:0]       length
);
	import isp_pkg::*;

	raw_t f_raw;
	raw_t q_raw;
	logic f_vld;
	logic full;
	logic take;
	logic pop;
	logic nempty;

	assign ready_in = !full;
	assign take     = valid_in && ready_in;

	isp_front u_front (
		.clk, .arst_n, .code_byte, .byte_addr, .take,
		.raw(f_raw), .raw_valid(f_vld)
	);

	isp_queue u_queue (
		.clk, .arst_n, .push(take && f_vld), .din(f_raw), .full,
		.pop, .dout(q_raw), .nempty
	);

	isp_back u_back (
		.clk, .arst_n, .raw(q_raw), .raw_valid(nempty), .pop,
		.valid, .ready, .page, .opcode, .addr_mode, .operand, .index_reg,
		.indirect, .illegal, .flow_break, .length
	);

endmodule
`default_nettype wire

// ===== rtl/isp_front.sv =====
// ----------------------------------------------------------------------------
// isp_front
// Byte tracker: prefix, opcode, postbyte and operand collection.
// ----------------------------------------------------------------------------
`default_nettype none
module isp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    code_byte,
	input  wire logic [15:0]   byte_addr,
	input  wire logic          take,
	output isp_pkg::raw_t      raw,
	output logic               raw_valid
);
	import isp_pkg::*;

	logic [1:0]  phase_q;
	logic [1:0]  page_q;
	logic [7:0]  opc_q;
	logic [4:0]  mode_q;
	logic [15:0] acc_q;
	logic [1:0]  left_q;
	logic [2:0]  cnt_q;
	logic        flow_q;
	logic [7:0]  post_q;

	cls_t        cls;
	logic [2:0]  cnt_n;
	logic [15:0] acc_n;

	assign cls   = classify(page_q, code_byte);
	assign cnt_n = cnt_q + 3'd1;
	assign acc_n = {acc_q[7:0], code_byte};

	always_comb begin
		raw_valid = 1'b0;
		raw = '{page: page_q, opcode: opc_q, mode: M_INH, opnd: 16'd0, post: post_q,
			nxt: byte_addr + 16'd1, ill: 1'b0, flow: flow_q, len: cnt_n};
		unique case (phase_q)
			PH_POST: begin
				raw.post = code_byte;
				if (!code_byte[7]) begin
					raw_valid = 1'b1; raw.mode = M_CONST;
				end else begin
					case (code_byte[3:0])
						4'h0, 4'h1, 4'h2, 4'h3: begin
							raw_valid = 1'b1; raw.mode = M_INC1 + {3'd0, code_byte[1:0]};
						end
						4'h4: begin raw_valid = 1'b1; raw.mode = M_CONST; end
						4'h5: begin raw_valid = 1'b1; raw.mode = M_BOFF; end
						4'h6: begin raw_valid = 1'b1; raw.mode = M_AOFF; end
						4'hB: begin raw_valid = 1'b1; raw.mode = M_DOFF; end
						4'h8, 4'h9, 4'hC, 4'hD, 4'hF: ;
						default: begin
							raw_valid = 1'b1; raw.mode = M_BADIDX; raw.ill = 1'b1;
						end
					endcase
				end
			end
			PH_OPER: begin
				raw_valid = (left_q == 2'd1);
				raw.mode = mode_q;
				raw.opnd = acc_n;
			end
			default: begin
				raw.opcode = code_byte;
				raw.flow = cls.flow;
				if (!((code_byte == 8'h10 || code_byte == 8'h11) && page_q == 2'd0) &&
					cls.mode != M_IDX && (cls.ill || cls.nb == 2'd0)) begin
					raw_valid = 1'b1;
					raw.ill = cls.ill;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OP;
			page_q  <= 2'd0;
			opc_q   <= 8'd0;
			mode_q  <= M_INH;
			acc_q   <= 16'd0;
			left_q  <= 2'd0;
			cnt_q   <= 3'd0;
			flow_q  <= 1'b0;
			post_q  <= 8'd0;
		end else if (take) begin
			cnt_q <= cnt_n;
			unique case (phase_q)
				PH_POST: begin
					post_q <= code_byte;
					acc_q  <= 16'd0;
					phase_q <= PH_OPER;
					case (code_byte[3:0])
						4'h8: begin mode_q <= M_CONST; left_q <= 2'd1; end
						4'h9: begin mode_q <= M_CONST; left_q <= 2'd2; end
						4'hC: begin mode_q <= M_PCREL; left_q <= 2'd1; end
						4'hD: begin mode_q <= M_PCREL; left_q <= 2'd2; end
						4'hF: begin mode_q <= M_EXTIND; left_q <= 2'd2; end
						default: ;
					endcase
				end
				PH_OPER: begin
					acc_q  <= acc_n;
					left_q <= left_q - 2'd1;
				end
				default: begin
					if ((code_byte == 8'h10 || code_byte == 8'h11) && page_q == 2'd0) begin
						page_q <= code_byte[1:0] + 2'd1;
					end else begin
						opc_q  <= code_byte;
						flow_q <= cls.flow;
						if (cls.mode == M_IDX) begin
							phase_q <= PH_POST;
						end else if (!(cls.ill || cls.nb == 2'd0)) begin
							mode_q  <= cls.mode;
							left_q  <= cls.nb;
							acc_q   <= 16'd0;
							phase_q <= PH_OPER;
						end
					end
				end
			endcase
			if (raw_valid) begin
				phase_q <= PH_OP;
				page_q  <= 2'd0;
				cnt_q   <= 3'd0;
				left_q  <= 2'd0;
				flow_q  <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/isp_queue.sv =====
// ----------------------------------------------------------------------------
// isp_queue
// Two-entry queue between the byte tracker and the result formatter.
// ----------------------------------------------------------------------------
`default_nettype none
module isp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  isp_pkg::raw_t      din,
	output logic               full,
	input  wire logic          pop,
	output isp_pkg::raw_t      dout,
	output logic               nempty
);
	import isp_pkg::*;

	raw_t       mem_q [QDEPTH];
	logic [0:0] wp_q;
	logic [0:0] rp_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'(QDEPTH));
	assign nempty = (cnt_q != 2'd0);
	assign dout   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/isp_back.sv =====
// ----------------------------------------------------------------------------
// isp_back
// Result formatter: target arithmetic, flow flags, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module isp_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  isp_pkg::raw_t     raw,
	input  wire logic         raw_valid,
	output logic              pop,
	output logic              valid,
	input  wire logic         ready,
	output logic [1:0]        page,
	output logic [7:0]        opcode,
	output logic [4:0]        addr_mode,
	output logic [15:0]       operand,
	output logic [1:0]        index_reg,
	output logic              indirect,
	output logic              illegal,
	output logic              flow_break,
	output logic [2:0]        length
);
	import isp_pkg::*;

	logic [4:0]  mode;
	logic [15:0] opnd;
	logic [15:0] s8;
	logic [1:0]  reg_n;
	logic        ind;
	logic        flow;

	assign pop = raw_valid && (!valid || ready);
	assign s8  = {{8{raw.opnd[7]}}, raw.opnd[7:0]};

	always_comb begin
		mode  = raw.mode;
		opnd  = raw.opnd;
		reg_n = 2'd0;
		ind   = 1'b0;
		flow  = raw.flow;
		case (raw.mode)
			M_REL8:  opnd = s8 + raw.nxt;
			M_REL16: opnd = raw.opnd + raw.nxt;
			M_RPAIR: begin
				if (raw.opnd[3:0] == 4'h5) flow = 1'b1;
				if (raw.opcode == 8'h1E && raw.opnd[7:4] == 4'h5) flow = 1'b1;
			end
			M_RLIST: begin
				if ((raw.opcode == 8'h35 || raw.opcode == 8'h37) && raw.opnd[7]) flow = 1'b1;
			end
			M_CONST: begin
				reg_n = raw.post[6:5];
				if (!raw.post[7]) begin
					opnd = {raw.post[4] ? 12'hFFF : 12'h000, raw.post[3:0]};
				end else begin
					ind = raw.post[4];
					if (raw.post[3:0] == 4'h8) opnd = s8;
					else if (raw.post[3:0] == 4'h4) opnd = 16'd0;
				end
			end
			M_INC1, M_INC2, M_DEC1, M_DEC2, M_AOFF, M_BOFF, M_DOFF: begin
				reg_n = raw.post[6:5];
				ind   = raw.post[4];
			end
			M_BADIDX: ind = raw.post[4];
			M_PCREL: begin
				opnd = (raw.post[3:0] == 4'hC ? s8 : raw.opnd) + raw.nxt;
				ind  = raw.post[4];
			end
			M_EXTIND: begin
				mode = M_EXT;
				ind  = raw.post[4];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (!valid || ready) begin
			valid <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			page       <= raw.page;
			opcode     <= raw.opcode;
			addr_mode  <= mode;
			operand    <= opnd;
			index_reg  <= reg_n;
			indirect   <= ind;
			illegal    <= raw.ill;
			flow_break <= flow;
			length     <= raw.len;
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_instruction_stream_predecoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_instruction_stream_predecoder
// Streams 6809 code bytes into the predecoder and checks every instruction
// record against a cycle-free decoder model kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_instruction_stream_predecoder;
	import isp_pkg::*;

	typedef struct packed {
		logic [1:0]  page;
		logic [7:0]  opcode;
		logic [4:0]  mode;
		logic [15:0] opnd;
		logic [1:0]  reg_sel;
		logic        ind;
		logic        ill;
		logic        flow;
		logic [2:0]  len;
	} insn_rec_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid_in = 1'b0;
	logic        ready_in;
	logic [7:0]  code_byte = '0;
	logic [15:0] byte_addr = '0;
	logic        valid;
	logic        ready = 1'b0;
	logic [1:0]  page;
	logic [7:0]  opcode;
	logic [4:0]  addr_mode;
	logic [15:0] operand;
	logic [1:0]  index_reg;
	logic        indirect;
	logic        illegal;
	logic        flow_break;
	logic [2:0]  length;

	insn_rec_t expected_insns[$];
	int        error_count = 0;
	int        idle_cycles = 0;
	bit        no_idle = 1'b0;
	logic [15:0] pc = 16'h0;

	// decoder state
	logic [1:0]  dec_phase = PH_OP;
	logic [1:0]  dec_page = '0;
	logic [7:0]  dec_opcode = '0;
	logic [4:0]  dec_mode = '0;
	logic [15:0] dec_accum = '0;
	logic [1:0]  dec_left = '0;
	logic [2:0]  dec_count = '0;
	logic        dec_flow = 1'b0;
	logic [7:0]  dec_post = '0;

	instruction_stream_predecoder uut (
		.clk(clk), .arst_n(arst_n),
		.valid_in(valid_in), .ready_in(ready_in),
		.code_byte(code_byte), .byte_addr(byte_addr),
		.valid(valid), .ready(ready),
		.page(page), .opcode(opcode), .addr_mode(addr_mode), .operand(operand),
		.index_reg(index_reg), .indirect(indirect), .illegal(illegal),
		.flow_break(flow_break), .length(length)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] sx8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	task automatic finish_insn(input logic [4:0] m, input logic [15:0] o,
			input logic [1:0] r, input logic i, input logic il, input logic f);
		expected_insns.push_back('{dec_page, dec_opcode, m, o, r, i, il, f, dec_count});
		dec_phase = PH_OP;
		dec_page = '0;
		dec_count = '0;
		dec_left = '0;
		dec_flow = 1'b0;
	endtask

	// own opcode table, independent of the package function
	task automatic opcode_class(input logic [1:0] pg, input logic [7:0] c,
			output logic [4:0] m, output logic [1:0] nb, output logic f,
			output logic il);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = c[7:4];
		lo = c[3:0];
		m = M_INH; nb = 0; f = 0; il = 0;
		if (hi == 0 || (hi >= 4 && hi <= 7)) begin
			f = (lo == 4'hE);
			if (lo == 1 || lo == 2 || lo == 5 || lo == 4'hB || c == 8'h4E || c == 8'h5E)
				il = 1;
			else if (hi == 0) begin m = M_DIR; nb = 1; end
			else if (hi == 6) m = M_IDX;
			else if (hi == 7) begin m = M_EXT; nb = 2; end
		end else if (hi == 1) begin
			if (lo == 2 || lo == 3 || lo == 9 || lo == 4'hD) ;
			else if (lo == 6) begin f = 1; m = M_REL16; nb = 2; end
			else if (lo == 7) begin m = M_REL16; nb = 2; end
			else if (lo == 4'hA || lo == 4'hC) begin m = M_IMM8; nb = 1; end
			else if (lo == 4'hE || lo == 4'hF) begin m = M_RPAIR; nb = 1; end
			else il = 1;
		end else if (hi == 2) begin
			f = (lo == 0);
			if (pg == 1) begin m = M_REL16; nb = 2; end
			else begin m = M_REL8; nb = 1; end
		end else if (hi == 3) begin
			if (lo < 4) m = M_IDX;
			else if (lo < 8) begin m = M_RLIST; nb = 1; end
			else if (lo == 8 || lo == 4'hE) il = 1;
			else if (lo == 9 || lo == 4'hB) f = 1;
			else if (lo == 4'hC) begin m = M_IMM8; nb = 1; end
			else if (lo == 4'hF) begin m = M_DIR; nb = 1; end
		end else begin
			case (hi[1:0])
				2'd0: begin
					if (lo[2:0] == 3'd7) il = 1;
					else if (lo == 4'hD) begin
						if (hi[2]) il = 1;
						else begin m = M_REL8; nb = 1; end
					end else if (lo == 3 || lo == 4'hC || lo == 4'hE) begin
						m = M_IMM16; nb = 2;
					end else begin m = M_IMM8; nb = 1; end
				end
				2'd1: begin m = M_DIR; nb = 1; end
				2'd2: m = M_IDX;
				default: begin m = M_EXT; nb = 2; end
			endcase
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic [15:0] a);
		logic [15:0] nxt;
		logic [4:0]  m;
		logic [1:0]  nb;
		logic [1:0]  r;
		logic        f;
		logic        il;
		logic        i;
		logic [15:0] o;
		nxt = a + 16'd1;
		dec_count = dec_count + 3'd1;
		if (dec_phase == PH_POST) begin
			dec_post = c;
			r = c[6:5];
			i = c[4];
			if (!c[7]) begin
				finish_insn(M_CONST, {{12{i}}, c[3:0]}, r, 1'b0, 1'b0, dec_flow);
				return;
			end
			case (c[3:0])
				4'h0, 4'h1, 4'h2, 4'h3: begin
					finish_insn(M_INC1 + c[3:0], '0, r, i, 1'b0, dec_flow); return;
				end
				4'h4: begin finish_insn(M_CONST, '0, r, i, 1'b0, dec_flow); return; end
				4'h5: begin finish_insn(M_BOFF, '0, r, i, 1'b0, dec_flow); return; end
				4'h6: begin finish_insn(M_AOFF, '0, r, i, 1'b0, dec_flow); return; end
				4'hB: begin finish_insn(M_DOFF, '0, r, i, 1'b0, dec_flow); return; end
				4'h8: begin dec_mode = M_CONST; dec_left = 1; end
				4'h9: begin dec_mode = M_CONST; dec_left = 2; end
				4'hC: begin dec_mode = M_PCREL; dec_left = 1; end
				4'hD: begin dec_mode = M_PCREL; dec_left = 2; end
				4'hF: begin dec_mode = M_EXTIND; dec_left = 2; end
				default: begin finish_insn(M_BADIDX, '0, 2'd0, i, 1'b1, dec_flow); return; end
			endcase
			dec_accum = '0;
			dec_phase = PH_OPER;
			return;
		end
		if (dec_phase == PH_OPER) begin
			dec_accum = {dec_accum[7:0], c};
			dec_left = dec_left - 2'd1;
			if (dec_left != 0) return;
			o = dec_accum; m = dec_mode; f = dec_flow; r = 0; i = 0;
			case (m)
				M_REL8: o = sx8(o[7:0]) + nxt;
				M_REL16: o = o + nxt;
				M_RPAIR: begin
					if (o[3:0] == 4'h5) f = 1;
					if (dec_opcode == 8'h1E && o[7:4] == 4'h5) f = 1;
				end
				M_RLIST:
					if ((dec_opcode == 8'h35 || dec_opcode == 8'h37) && o[7]) f = 1;
				M_CONST: begin
					if (dec_post[3:0] == 4'h8) o = sx8(o[7:0]);
					r = dec_post[6:5]; i = dec_post[4];
				end
				M_PCREL: begin
					o = (dec_post[3:0] == 4'hC ? sx8(o[7:0]) : o) + nxt;
					i = dec_post[4];
				end
				M_EXTIND: begin m = M_EXT; i = dec_post[4]; end
				default: ;
			endcase
			finish_insn(m, o, r, i, 1'b0, f);
			return;
		end
		dec_phase = PH_OP;
		if ((c == 8'h10 || c == 8'h11) && dec_page == 0) begin
			dec_page = c[1:0] + 2'd1;
			return;
		end
		dec_opcode = c;
		opcode_class(dec_page, c, m, nb, f, il);
		dec_flow = f;
		if (m == M_IDX) begin dec_phase = PH_POST; return; end
		if (il || nb == 0) begin finish_insn(M_INH, '0, 2'd0, 1'b0, il, f); return; end
		dec_mode = m;
		dec_left = nb;
		dec_accum = '0;
		dec_phase = PH_OPER;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		if (!no_idle)
			while ($urandom_range(99) < 28) begin
				valid_in <= 1'b0;
				@(posedge clk);
			end
		valid_in <= 1'b1;
		code_byte <= c;
		byte_addr <= pc;
		@(posedge clk);
		while (!ready_in) @(posedge clk);
		predict_byte(c, pc);
		pc = pc + 16'd1;
	endtask

	task automatic send_op(input logic [7:0] b0, input int n, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		send_byte(b0);
		if (n > 1) send_byte(b1);
		if (n > 2) send_byte(b2);
		if (n > 3) send_byte(b3);
	endtask

	task automatic drain_results();
		valid_in <= 1'b0;
		@(posedge clk);
		while (expected_insns.size() != 0) @(posedge clk);
	endtask

	// well-formed instruction with random contents
	task automatic send_random_insn();
		logic [7:0] c;
		logic [7:0] p;
		logic [4:0] m;
		logic [1:0] nb;
		logic f;
		logic il;
		logic [1:0] pg;
		int r;
		pg = 0;
		r = $urandom_range(9);
		if (r == 0) begin send_byte(8'h10); pg = 1; end
		else if (r == 1) begin send_byte(8'h11); pg = 2; end
		c = $urandom_range(255);
		send_byte(c);
		if ((c == 8'h10 || c == 8'h11) && pg == 0) begin
			pg = c[1:0] + 2'd1;
			c = $urandom_range(255);
			send_byte(c);
		end
		if ((c == 8'h10 || c == 8'h11) && pg != 0) return;
		opcode_class(pg, c, m, nb, f, il);
		if (m == M_IDX) begin
			p = $urandom_range(255);
			send_byte(p);
			if (p[7]) case (p[3:0])
				4'h8, 4'hC: nb = 1;
				4'h9, 4'hD, 4'hF: nb = 2;
				default: nb = 0;
			endcase
			else nb = 0;
		end else if (il) nb = 0;
		repeat (nb) send_byte($urandom_range(255));
	endtask

	always @(posedge clk) begin
		insn_rec_t w;
		if (valid_in && ready_in || valid && ready) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && valid && ready) begin
			if (expected_insns.size() == 0) begin
				$display("mismatch: unexpected record opcode %h", opcode);
				error_count++;
			end else begin
				w = expected_insns.pop_front();
				if (page !== w.page) report_mismatch("page", page, w.page);
				if (opcode !== w.opcode) report_mismatch("opcode", opcode, w.opcode);
				if (addr_mode !== w.mode) report_mismatch("addr_mode", addr_mode, w.mode);
				if (operand !== w.opnd) report_mismatch("operand", operand, w.opnd);
				if (index_reg !== w.reg_sel) report_mismatch("index_reg", index_reg, w.reg_sel);
				if (indirect !== w.ind) report_mismatch("indirect", indirect, w.ind);
				if (illegal !== w.ill) report_mismatch("illegal", illegal, w.ill);
				if (flow_break !== w.flow) report_mismatch("flow_break", flow_break, w.flow);
				if (length !== w.len) report_mismatch("length", length, w.len);
			end
		end
		ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
	end

	task automatic test_directed();
		send_op(8'h12, 1, 0, 0, 0);              // nop, inherent
		send_op(8'h01, 1, 0, 0, 0);              // undefined opcode
		send_op(8'h10, 2, 8'h10, 0, 0);          // repeated prefix
		send_op(8'h11, 2, 8'h10, 0, 0);
		send_op(8'h86, 2, 8'hFF, 0, 0);          // imm8
		send_op(8'hCC, 3, 8'hFF, 8'hFF, 0);      // imm16
		send_op(8'h20, 2, 8'h80, 0, 0);          // bra backwards
		send_op(8'h10, 4, 8'h27, 8'h7F, 8'hFF);  // lbeq
		send_op(8'h16, 3, 8'hFF, 8'hFE, 0);      // lbra
		send_op(8'h7E, 3, 8'h00, 8'h00, 0);      // jmp extended
		send_op(8'h3F, 2, 8'h55, 0, 0);          // swi
		send_op(8'h35, 2, 8'h80, 0, 0);          // puls pc
		send_op(8'h1F, 2, 8'h15, 0, 0);          // tfr x,pc
		send_op(8'h1E, 2, 8'h51, 0, 0);          // exg pc,x
		send_op(8'hA6, 2, 8'h1F, 0, 0);          // 5-bit negative offset
		send_op(8'h6E, 2, 8'hF1, 0, 0);          // jmp [,s++], indirect auto-increment
		send_op(8'hA6, 2, 8'h87, 0, 0);          // undefined postbyte
		send_op(8'hA6, 3, 8'hA8, 8'h80, 0);      // 8-bit offset
		send_op(8'h11, 4, 8'hA6, 8'h9D, 8'hFF);  // pc rel 16 indirect, page 2; its second offset byte is the next line's A6
		send_op(8'hA6, 4, 8'h9F, 8'hFF, 8'hFF);  // then 9F FF decodes as direct, and FF opens an extended op ended by 10 AE
		send_op(8'h10, 4, 8'hAE, 8'h9C, 8'h80);
		send_op(8'h32, 2, 8'hE6, 0, 0);          // leas a,s
		drain_results();
	endtask

	task automatic test_stall_pause();
		repeat (8) send_random_insn();
		drain_results();
		repeat (8) send_random_insn();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (150) send_random_insn();
		no_idle = 1'b0;
	endtask

	task automatic test_random_stream();
		int n;
		n = 0;
		while (n < 760) begin
			if ($urandom_range(9) == 0) begin
				send_byte($urandom_range(255));
				pc = $urandom_range(65535);
				n++;
			end else begin
				send_random_insn();
				n += 2;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stall_pause();
		test_back_to_back();
		test_random_stream();
		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
